[rtl/core/lbf_pkg.sv]
package lbf_pkg;

  localparam int CHANNELS = 8;
  localparam int MAX_OUT  = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = $clog2(MAX_OUT + 1);
  localparam int QDEPTH   = 2;
  localparam int Q_AW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 15;
  localparam int D_W      = 25;
  localparam int STEP_W   = 17;
  localparam int LVL_W    = 10;
  localparam int PROD_W   = 2 * D_W;
  localparam int DIV_SHIFT = 32;

  localparam logic [9:0]       US_PER_MS  = 10'd1000;
  // floor(2^32 / 255); the quotient it yields is low by at most one.
  localparam logic [D_W-1:0]   RECIP_255  = 25'd16843009;
  localparam logic [D_W-1:0]   DIV_BY     = 25'd255;
  localparam logic [7:0]       FULL_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_BLINK = 2'd1,
    ACT_FADE  = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    LAMP_IDLE = 3'd0,
    LAMP_LIT  = 3'd1,
    LAMP_DARK = 3'd2,
    LAMP_RISE = 3'd3,
    LAMP_FALL = 3'd4
  } mode_t;

  typedef struct packed {
    action_t                 action;
    logic [IDX_W-1:0]        idx;
    logic [D_W-1:0]          ivl_us;
    logic [STEP_W-1:0]       step_us;
    logic [TIME_W-1:0]       now;
    logic [TIME_W-1:0]       start_time;
  } cmd_t;

endpackage

[rtl/core/lbf_if.sv]
interface lbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  led_index;
  logic [14:0] interval_ms;
  logic [14:0] fade_ms;
  logic [31:0] now_us;

  modport source(output valid, action, led_index, interval_ms, fade_ms, now_us, input ready);
  modport sink(input valid, action, led_index, interval_ms, fade_ms, now_us, output ready);
endinterface

interface lbf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] channel;
  logic       drive_write;
  logic [7:0] drive_level;
  logic       last_result;

  modport source(output valid, channel, drive_write, drive_level, last_result, input ready);
  modport sink(input valid, channel, drive_write, drive_level, last_result, output ready);
endinterface

[rtl/core/lbf_front.sv]
module lbf_front import lbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lbf_in_if.sink     cmd,
  output logic       push,
  output cmd_t       push_data,
  input  logic       full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_DIV  = 5'b00100,
    F_FIX  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            state;
  action_t            action;
  logic [IDX_W-1:0]   idx;
  logic [TIME_W-1:0]  now;
  logic [D_W-1:0]     fade_us;
  logic [D_W-1:0]     ivl_us;
  logic [PROD_W-1:0]  prod;
  logic [STEP_W-1:0]  quot;
  cmd_t               entry;

  logic [D_W-1:0]     quot_x255;
  logic [D_W-1:0]     rem;
  logic [STEP_W-1:0]  step_fix;

  assign cmd.ready = (state == F_IDLE);
  assign push      = (state == F_PUSH) && !full;
  assign push_data = entry;

  // Remainder of the estimated quotient; one correction step finishes the division.
  always_comb begin
    quot_x255 = {quot, 8'b0} - {8'b0, quot};
    rem       = fade_us - quot_x255;
    step_fix  = (rem >= DIV_BY) ? quot + 1'b1 : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (cmd.valid) begin
            action  <= action_t'(cmd.action);
            idx     <= cmd.led_index;
            now     <= cmd.now_us;
            fade_us <= D_W'(cmd.fade_ms * US_PER_MS);
            ivl_us  <= D_W'(cmd.interval_ms * US_PER_MS);
            state   <= F_MUL;
          end
        end
        F_MUL: begin
          prod  <= {{(PROD_W-D_W){1'b0}}, fade_us} * {{(PROD_W-D_W){1'b0}}, RECIP_255};
          state <= F_DIV;
        end
        F_DIV: begin
          quot  <= prod[DIV_SHIFT +: STEP_W];
          state <= F_FIX;
        end
        F_FIX: begin
          entry.action     <= action;
          entry.idx        <= idx;
          entry.ivl_us     <= ivl_us;
          entry.step_us    <= step_fix;
          entry.now        <= now;
          entry.start_time <= now - {{(TIME_W-D_W){1'b0}}, ivl_us};
          state            <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/lbf_queue.sv]
module lbf_queue import lbf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  cmd_t            entries [QDEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full      = (count == (Q_AW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/lbf_back.sv]
module lbf_back import lbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       pop,
  lbf_out_if.source  res
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SCAN  = 3'b010,
    B_FLUSH = 3'b100
  } bstate_t;

  bstate_t                  state;
  mode_t                    mode    [CHANNELS];
  logic [TIME_W-1:0]        ev_time [CHANNELS];
  logic [D_W-1:0]           ivl_us  [CHANNELS];
  logic [STEP_W-1:0]        step_us [CHANNELS];
  logic signed [LVL_W-1:0]  level   [CHANNELS];

  logic [CH_W-1:0]    ch;
  logic [CNT_W-1:0]   cnt;
  logic [TIME_W-1:0]  now;
  logic               pend_valid;
  logic [2:0]         pend_ch;
  logic [7:0]         pend_lvl;
  logic               o_valid;
  logic [2:0]         o_ch;
  logic [7:0]         o_lvl;
  logic               o_last;

  mode_t                    cur_mode;
  logic [TIME_W-1:0]        cur_ev;
  logic signed [LVL_W-1:0]  cur_lvl;
  logic [TIME_W-1:0]        due;
  logic                     active;
  logic                     hit;
  logic                     wr;
  logic [7:0]               wr_lvl;
  logic                     emit;
  logic                     out_free;
  logic                     stall;
  logic                     load_out;
  logic [CH_W-1:0]          cidx;
  logic                     in_range;

  assign res.valid       = o_valid;
  assign res.channel     = o_ch;
  assign res.drive_write = 1'b1;
  assign res.drive_level = o_lvl;
  assign res.last_result = o_last;

  assign pop      = (state == B_IDLE) && q_valid;
  assign out_free = !o_valid || res.ready;
  assign cidx     = CH_W'(q_data.idx);
  assign in_range = int'(q_data.idx) < CHANNELS;

  always_comb begin
    cur_mode = mode[ch];
    cur_ev   = ev_time[ch];
    cur_lvl  = level[ch];
    due      = cur_ev + {{(TIME_W-D_W){1'b0}}, ivl_us[ch]};
    hit      = (due <= now);
    active   = cur_mode inside {LAMP_LIT, LAMP_DARK, LAMP_RISE, LAMP_FALL};
    wr_lvl   = cur_lvl[7:0];
    case (cur_mode)
      LAMP_LIT: begin
        wr     = hit;
        wr_lvl = 8'd0;
      end
      LAMP_DARK: begin
        wr     = hit;
        wr_lvl = FULL_LEVEL;
      end
      LAMP_RISE: begin
        wr = hit && (cur_lvl <= $signed({2'b00, FULL_LEVEL}));
      end
      LAMP_FALL: begin
        wr = hit && !cur_lvl[LVL_W-1];
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    // Results past the per-item limit are dropped, but the channel still advances.
    emit  = wr && (cnt < CNT_W'(MAX_OUT));
    stall = emit && pend_valid && !out_free;
    load_out = ((state == B_SCAN) && !stall && emit && pend_valid) ||
               ((state == B_FLUSH) && pend_valid && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mode[i]    <= LAMP_IDLE;
        ev_time[i] <= '0;
        ivl_us[i]  <= '0;
        step_us[i] <= '0;
        level[i]   <= '0;
      end
      state      <= B_IDLE;
      ch         <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (q_data.action == ACT_TICK) begin
              now   <= q_data.now;
              ch    <= '0;
              cnt   <= '0;
              state <= B_SCAN;
            end else begin
              if (in_range) begin
                pend_valid <= 1'b1;
                pend_ch    <= q_data.idx;
                pend_lvl   <= (q_data.action == ACT_BLINK) ? FULL_LEVEL : 8'd0;
                case (q_data.action)
                  ACT_BLINK: begin
                    mode[cidx]    <= LAMP_LIT;
                    ivl_us[cidx]  <= q_data.ivl_us;
                    ev_time[cidx] <= q_data.start_time;
                  end
                  ACT_FADE: begin
                    mode[cidx]    <= LAMP_RISE;
                    ivl_us[cidx]  <= q_data.ivl_us;
                    step_us[cidx] <= q_data.step_us;
                    level[cidx]   <= '0;
                    ev_time[cidx] <= q_data.start_time;
                  end
                  default: begin
                    mode[cidx] <= LAMP_IDLE;
                  end
                endcase
              end
              state <= B_FLUSH;
            end
          end
        end
        B_SCAN: begin
          if (!stall) begin
            if (active && hit) begin
              case (cur_mode)
                LAMP_LIT: begin
                  mode[ch]    <= LAMP_DARK;
                  ev_time[ch] <= now;
                end
                LAMP_DARK: begin
                  mode[ch]    <= LAMP_LIT;
                  ev_time[ch] <= now;
                end
                LAMP_RISE: begin
                  if (wr) begin
                    ev_time[ch] <= cur_ev + {{(TIME_W-STEP_W){1'b0}}, step_us[ch]};
                    level[ch]   <= cur_lvl + 10'sd1;
                  end else begin
                    mode[ch]    <= LAMP_FALL;
                    level[ch]   <= $signed({2'b00, FULL_LEVEL});
                    ev_time[ch] <= now;
                  end
                end
                default: begin
                  if (wr) begin
                    ev_time[ch] <= cur_ev + {{(TIME_W-STEP_W){1'b0}}, step_us[ch]};
                    level[ch]   <= cur_lvl - 10'sd1;
                  end else begin
                    mode[ch]    <= LAMP_RISE;
                    level[ch]   <= '0;
                    ev_time[ch] <= now;
                  end
                end
              endcase
            end else if (active && (now < cur_ev)) begin
              // Time ran backwards: resynchronize to the current time.
              ev_time[ch] <= now;
            end
            if (emit) begin
              if (pend_valid) begin
                o_ch    <= pend_ch;
                o_lvl   <= pend_lvl;
                o_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_ch    <= 3'(ch);
              pend_lvl   <= wr_lvl;
              cnt        <= cnt + 1'b1;
            end
            if (ch == CH_W'(CHANNELS - 1)) begin
              state <= B_FLUSH;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        B_FLUSH: begin
          if (!pend_valid) begin
            state <= B_IDLE;
          end else if (out_free) begin
            o_ch       <= pend_ch;
            o_lvl      <= pend_lvl;
            o_last     <= 1'b1;
            pend_valid <= 1'b0;
            state      <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> !pend_valid)
    else $error("pending result held while back end is idle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_OUT))
    else $error("result count exceeds the per-item limit");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_FLUSH && pend_valid && out_free) |=> (state == B_IDLE && o_valid && o_last))
    else $error("final result not delivered on flush");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN && stall) |=> (state == B_SCAN && ch == $past(ch)))
    else $error("scan advanced while the output was blocked");

endmodule

[rtl/core/multi_channel_led_blink_fade.sv]
// LED blink and fade controller for eight channels. Start blink, start fade and stop
// commands address one channel and return a single result item; a tick item scans every
// channel and returns one item per channel whose output changes, the final one marked by
// last_result, or none at all. The front end steps items through capture, multiply and
// quotient stages for the fade step delay, correction and queue push, taking no new item
// before the push, stalling on a full queue, and holds up to two items in its queue while
// the back end works. The back end, which owns the channel table, takes a command and
// delivers its result; on a tick it takes the item, visits one channel per cycle unless
// stalled, then delivers the final result; this scan sets the sustained rate for tick
// traffic. A stalled result port pauses the scan only when a second result is ready to
// leave. Time is compared modulo 2^32 against now_us in microseconds.
module multi_channel_led_blink_fade import lbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lbf_in_if.sink     cmd,
  lbf_out_if.source  res
);

  logic push;
  logic full;
  cmd_t push_data;
  logic pop;
  cmd_t pop_data;
  logic not_empty;

  lbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  lbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  lbf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .res     (res)
  );

endmodule

[sim/multi_channel_led_blink_fade_tb.sv]
`timescale 1ns / 100ps

module multi_channel_led_blink_fade_tb;
  import lbf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 40;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic [2:0] ch;
    logic       wr;
    logic [7:0] lvl;
    logic       last;
  } led_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbf_in_if  cmd_bus ();
  lbf_out_if res_bus ();

  multi_channel_led_blink_fade dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  always #5 clk = ~clk;

  // Channel table as the block should hold it.
  mode_t       lamp_mode [CHANNELS] = '{default: LAMP_IDLE};
  logic [31:0] event_us  [CHANNELS] = '{default: '0};
  logic [14:0] hold_ms   [CHANNELS] = '{default: '0};
  logic [16:0] step_us   [CHANNELS] = '{default: '0};
  int          ramp_lvl  [CHANNELS] = '{default: 0};

  led_write_t owed_writes [$];

  logic [31:0] wall_us = '0;
  int burst_left     = 0;
  int holds_asked    = 0;
  int holds_served   = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int ticks_sent     = 0;
  int writes_checked = 0;
  int busiest_tick   = 0;
  int ramp_turns     = 0;
  int cycle_count    = 0;

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic led_write_t write_of(int c, logic [7:0] lvl);
    return {3'(c), 1'b1, lvl, 1'b0};
  endfunction

  task automatic compute_led_writes(action_t act, logic [2:0] idx, logic [14:0] ivl,
                                    logic [14:0] fms, logic [31:0] now);
    led_write_t batch [$];
    led_write_t tail;
    logic [31:0] due;
    logic [31:0] prod;
    if (act == ACT_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (lamp_mode[c] != LAMP_IDLE) begin
          due = event_us[c] + 32'(hold_ms[c]) * 32'(US_PER_MS);
          if (due <= now) begin
            case (lamp_mode[c])
              LAMP_DARK: begin
                batch.push_back(write_of(c, FULL_LEVEL));
                lamp_mode[c] = LAMP_LIT;
                event_us[c]  = now;
              end
              LAMP_LIT: begin
                batch.push_back(write_of(c, 8'd0));
                lamp_mode[c] = LAMP_DARK;
                event_us[c]  = now;
              end
              LAMP_RISE: begin
                if (ramp_lvl[c] <= int'(FULL_LEVEL)) begin
                  event_us[c] = event_us[c] + 32'(step_us[c]);
                  batch.push_back(write_of(c, 8'(ramp_lvl[c])));
                  ramp_lvl[c]++;
                end else begin
                  lamp_mode[c] = LAMP_FALL;
                  ramp_lvl[c]  = int'(FULL_LEVEL);
                  event_us[c]  = now;
                  ramp_turns++;
                end
              end
              LAMP_FALL: begin
                if (ramp_lvl[c] >= 0) begin
                  event_us[c] = event_us[c] + 32'(step_us[c]);
                  batch.push_back(write_of(c, 8'(ramp_lvl[c])));
                  ramp_lvl[c]--;
                end else begin
                  lamp_mode[c] = LAMP_RISE;
                  ramp_lvl[c]  = 0;
                  event_us[c]  = now;
                  ramp_turns++;
                end
              end
              default: ;
            endcase
          end else if (now < event_us[c]) begin
            // Time went backwards: take the new time as the last event.
            event_us[c] = now;
          end
        end
      end
      if (batch.size() > busiest_tick) busiest_tick = batch.size();
    end else begin
      case (act)
        ACT_BLINK: begin
          batch.push_back(write_of(idx, FULL_LEVEL));
          lamp_mode[idx] = LAMP_LIT;
          hold_ms[idx]   = ivl;
          event_us[idx]  = now - 32'(ivl) * 32'(US_PER_MS);
        end
        ACT_FADE: begin
          batch.push_back(write_of(idx, 8'd0));
          prod           = 32'(fms) * 32'(US_PER_MS);
          lamp_mode[idx] = LAMP_RISE;
          hold_ms[idx]   = ivl;
          step_us[idx]   = 17'(prod / 32'd255);
          ramp_lvl[idx]  = 0;
          event_us[idx]  = now - 32'(ivl) * 32'(US_PER_MS);
        end
        default: begin
          batch.push_back(write_of(idx, 8'd0));
          lamp_mode[idx] = LAMP_IDLE;
        end
      endcase
    end
    if (batch.size() > 0) begin
      tail = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[i]) owed_writes.push_back(batch[i]);
  endtask

  // Offers one item in bursts with random gaps, waits for its handshake and
  // then predicts the writes it causes.
  task automatic send_item(action_t act, logic [2:0] idx, logic [14:0] ivl,
                           logic [14:0] fms, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_bus.valid       <= 1'b1;
    cmd_bus.action      <= act;
    cmd_bus.led_index   <= idx;
    cmd_bus.interval_ms <= ivl;
    cmd_bus.fade_ms     <= fms;
    cmd_bus.now_us      <= now;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    compute_led_writes(act, idx, ivl, fms, now);
    items_sent++;
    if (act == ACT_TICK) ticks_sent++;
  endtask

  task automatic wait_writes_done();
    int waited;
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (owed_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (owed_writes.size() != 0) begin
      report_mismatch($sformatf("%0d expected writes never arrived", owed_writes.size()));
      owed_writes.delete();
    end
    // A quiet tick may still be scanning after the last write has left.
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic test_blink_toggle();
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd0);
    send_item(ACT_BLINK, 3'd0, 15'd0, 15'h7FFF, 32'd0);
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd0);
    // Tick fields other than the time are ignored.
    send_item(ACT_TICK, 3'd7, 15'h7FFF, 15'h7FFF, 32'd0);
  endtask

  task automatic test_fade_and_resync();
    send_item(ACT_FADE, 3'd7, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
    send_item(ACT_BLINK, 3'd3, 15'h7FFF, 15'd0, 32'd5);
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd10);
    send_item(ACT_STOP, 3'd0, 15'd0, 15'd0, 32'd10);
    send_item(ACT_STOP, 3'd6, 15'h7FFF, 15'h7FFF, 32'd10);
    send_item(ACT_FADE, 3'd5, 15'd0, 15'd0, 32'd100);
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd50);
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd60);
  endtask

  task automatic test_all_channels_due();
    send_item(ACT_BLINK, 3'd0, 15'd0, 15'd0, 32'd60);
    send_item(ACT_BLINK, 3'd1, 15'd0, 15'd0, 32'd60);
    send_item(ACT_BLINK, 3'd2, 15'd0, 15'd0, 32'd60);
    send_item(ACT_BLINK, 3'd4, 15'd0, 15'd0, 32'd60);
    send_item(ACT_BLINK, 3'd6, 15'd0, 15'd0, 32'd60);
    send_item(ACT_FADE, 3'd3, 15'd0, 15'd0, 32'd60);
    send_item(ACT_FADE, 3'd7, 15'd0, 15'd0, 32'd60);
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd70);
    send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, 32'd70);
    wall_us = 32'd70;
  endtask

  // Mostly ticks on a moving clock. Commands stay off channel 7 so that its
  // fast ramp runs long enough to reach the top and turn around.
  task automatic test_random_traffic(int count);
    action_t     act;
    logic [2:0]  idx;
    logic [14:0] ivl;
    logic [14:0] fms;
    logic [31:0] now;
    int          roll;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 88) begin
        roll = $urandom_range(0, 79);
        if (roll == 0) wall_us = $urandom;
        else if (roll == 1) wall_us = wall_us - $urandom_range(1, 5000);
        else wall_us = wall_us + $urandom_range(0, 2500);
        send_item(ACT_TICK, 3'($urandom), 15'($urandom), 15'($urandom), wall_us);
      end else begin
        act = action_t'($urandom_range(1, 3));
        idx = 3'($urandom_range(0, 6));
        ivl = ($urandom_range(0, 3) != 0) ? 15'($urandom_range(0, 3)) : 15'($urandom);
        fms = ($urandom_range(0, 3) != 0) ? 15'($urandom_range(0, 4)) : 15'($urandom);
        now = ($urandom_range(0, 9) != 0) ? wall_us : $urandom;
        send_item(act, idx, ivl, fms, now);
      end
    end
  endtask

  task automatic test_result_backpressure();
    send_item(ACT_BLINK, 3'd0, 15'd0, 15'd0, wall_us);
    send_item(ACT_BLINK, 3'd1, 15'd0, 15'd0, wall_us);
    send_item(ACT_BLINK, 3'd2, 15'd0, 15'd0, wall_us);
    holds_asked++;
    repeat (30) begin
      wall_us = wall_us + 32'd500;
      send_item(ACT_TICK, 3'd0, 15'd0, 15'd0, wall_us);
    end
  endtask

  // Result port: ready follows a rotating mask that changes every segment,
  // with an occasional long hold-off on request.
  initial begin : write_sink
    logic [7:0] mask;
    int seg_left;
    int phase;
    res_bus.ready = 1'b0;
    mask = 8'hFF;
    seg_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_served++;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 80);
          case ($urandom_range(0, 3))
            0: mask = 8'hFF;
            1: mask = 8'b1011_0111;
            2: mask = 8'b0101_0101;
            default: mask = 8'($urandom) | 8'h01;
          endcase
        end
        seg_left--;
        res_bus.ready <= mask[phase];
        phase = (phase + 1) % 8;
      end
    end
  end

  always @(posedge clk) begin
    led_write_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (owed_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write: channel %0d level %0d",
                                  res_bus.channel, res_bus.drive_level));
      end else begin
        want = owed_writes.pop_front();
        if (res_bus.channel !== want.ch)
          report_mismatch($sformatf("write %0d: channel %0d, expected %0d",
                                    writes_checked, res_bus.channel, want.ch));
        if (res_bus.drive_write !== want.wr)
          report_mismatch($sformatf("write %0d: drive_write %0b, expected %0b",
                                    writes_checked, res_bus.drive_write, want.wr));
        if (res_bus.drive_level !== want.lvl)
          report_mismatch($sformatf("write %0d: level %0d, expected %0d",
                                    writes_checked, res_bus.drive_level, want.lvl));
        if (res_bus.last_result !== want.last)
          report_mismatch($sformatf("write %0d: last_result %0b, expected %0b",
                                    writes_checked, res_bus.last_result, want.last));
        writes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d writes outstanding",
               cycle_count, owed_writes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cmd_bus.valid       = 1'b0;
    cmd_bus.action      = ACT_TICK;
    cmd_bus.led_index   = '0;
    cmd_bus.interval_ms = '0;
    cmd_bus.fade_ms     = '0;
    cmd_bus.now_us      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_blink_toggle();
    test_fade_and_resync();
    test_all_channels_due();
    wait_writes_done();

    // Start near the 32-bit wrap so the clock rolls over during traffic.
    wall_us = 32'hFFFC_0000;
    test_random_traffic(128);
    test_result_backpressure();
    wait_writes_done();
    test_random_traffic(128);
    wait_writes_done();

    $display("Covered %0d items (%0d ticks, %0d commands), %0d LED writes checked.",
             items_sent, ticks_sent, items_sent - ticks_sent, writes_checked);
    $display("Busiest tick wrote %0d channels; %0d ramp reversals; one %0d-cycle hold-off.",
             busiest_tick, ramp_turns, LONG_HOLD);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
